### design/phlp_pkg.sv
// Shared codes and constants of the packet header length parser.
package phlp_pkg;

  localparam logic [2:0] PhEth  = 3'd0;
  localparam logic [2:0] PhIpv4 = 3'd1;
  localparam logic [2:0] PhIpv6 = 3'd2;
  localparam logic [2:0] PhTcp  = 3'd3;
  localparam logic [2:0] PhDone = 3'd4;

  localparam logic [2:0] VerdictOk     = 3'd0;
  localparam logic [2:0] VerdictNotIp  = 3'd1;
  localparam logic [2:0] VerdictNotL4  = 3'd2;
  localparam logic [2:0] VerdictTrunc  = 3'd3;
  localparam logic [2:0] VerdictTags   = 3'd4;

  localparam logic [1:0] L3None = 2'd0;
  localparam logic [1:0] L3Ipv4 = 2'd1;
  localparam logic [1:0] L3Ipv6 = 2'd2;

  localparam logic [1:0] L4None = 2'd0;
  localparam logic [1:0] L4Tcp  = 2'd1;
  localparam logic [1:0] L4Udp  = 2'd2;

  localparam logic [15:0] EtypeVlan = 16'h8100;
  localparam logic [15:0] EtypeQinq = 16'h88A8;
  localparam logic [15:0] EtypeIpv4 = 16'h0800;
  localparam logic [15:0] EtypeIpv6 = 16'h86DD;

  localparam logic [7:0] ProtoTcp = 8'd6;
  localparam logic [7:0] ProtoUdp = 8'd17;

  localparam logic [4:0] EthHdrLen  = 5'd14;
  localparam logic [5:0] Ipv6HdrLen = 6'd40;
  localparam logic [5:0] UdpHdrLen  = 6'd8;

endpackage

### design/packet_header_length_parser.sv
// Top level: byte-serial Ethernet/VLAN/IPv4/IPv6/TCP/UDP header length parser.
// Takes one frame byte per cycle with no gaps required; a new byte is accepted
// in every cycle unless a finished result sits in the output register and
// out_ready_i is low. The per-byte work compares the byte offset against the
// field positions of the current phase, done between the parse state registers
// and the result register. The result appears on the cycle after the transfer
// of the frame's last byte, and the parser is back at its start state for the
// next frame at once. Byte offsets saturate at 2**OFFSET_BITS - 1.
module packet_header_length_parser
  import phlp_pkg::*;
#(
  parameter int MAX_TAGS    = 4,
  parameter int OFFSET_BITS = 11
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] pkt_byte_i,
  input  logic       last_byte_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [4:0] l2_length_o,
  output logic [5:0] l3_length_o,
  output logic [5:0] l4_length_o,
  output logic [1:0] l3_kind_o,
  output logic [1:0] l4_kind_o,
  output logic [2:0] verdict_o
);

  localparam int OW = OFFSET_BITS;
  localparam logic [OW-1:0] OffMax = {OW{1'b1}};

  logic [OW-1:0] off_q, off_d;
  logic [2:0]    phase_q, phase_d;
  logic [7:0]    prev_q;
  logic [2:0]    tag_q, tag_d;
  logic [4:0]    l2_q, l2_d;
  logic [5:0]    l3_q, l3_d;
  logic [5:0]    l4_q, l4_d;
  logic [1:0]    l3k_q, l3k_d;
  logic [1:0]    l4k_q, l4k_d;
  logic [2:0]    verd_q, verd_d;

  logic          out_valid_q;
  logic [4:0]    res_l2_q;
  logic [5:0]    res_l3_q, res_l4_q;
  logic [1:0]    res_l3k_q, res_l4k_q;
  logic [2:0]    res_verd_q;

  logic          accept;
  logic [15:0]   etype;
  logic [4:0]    tag4;
  logic [OW-1:0] base;
  logic [OW-1:0] pos_etype, pos_ihl, pos_proto, pos_nh, pos_tcp;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;
  assign etype      = {prev_q, pkt_byte_i};
  assign tag4       = {tag_q, 2'b00};
  assign base       = OW'(EthHdrLen) + OW'(tag4);
  assign pos_etype  = base - OW'(1);
  assign pos_ihl    = base;
  assign pos_proto  = base + OW'(9);
  assign pos_nh     = base + OW'(6);
  assign pos_tcp    = base + OW'(l3_q) + OW'(12);

  always_comb begin
    phase_d = phase_q;
    tag_d   = tag_q;
    l2_d    = l2_q;
    l3_d    = l3_q;
    l4_d    = l4_q;
    l3k_d   = l3k_q;
    l4k_d   = l4k_q;
    verd_d  = verd_q;
    off_d   = (off_q == OffMax) ? off_q : off_q + OW'(1);

    case (phase_q)
      PhEth: begin
        if (off_q == pos_etype) begin
          if (etype == EtypeVlan || etype == EtypeQinq) begin
            if (tag_q >= 3'(MAX_TAGS)) begin
              l3k_d   = L3None;
              l4k_d   = L4None;
              verd_d  = VerdictTags;
              phase_d = PhDone;
            end else begin
              tag_d = tag_q + 3'd1;
              l2_d  = EthHdrLen + {tag_d, 2'b00};
            end
          end else if (etype == EtypeIpv4) begin
            l3k_d   = L3Ipv4;
            l4k_d   = L4None;
            verd_d  = VerdictOk;
            phase_d = PhIpv4;
          end else if (etype == EtypeIpv6) begin
            l3_d    = Ipv6HdrLen;
            l3k_d   = L3Ipv6;
            l4k_d   = L4None;
            verd_d  = VerdictOk;
            phase_d = PhIpv6;
          end else begin
            l3k_d   = L3None;
            l4k_d   = L4None;
            verd_d  = VerdictNotIp;
            phase_d = PhDone;
          end
        end
      end
      PhIpv4, PhIpv6: begin
        if (phase_q == PhIpv4 && off_q == pos_ihl) begin
          l3_d = {pkt_byte_i[3:0], 2'b00};
        end else if ((phase_q == PhIpv4 && off_q == pos_proto) ||
                     (phase_q == PhIpv6 && off_q == pos_nh)) begin
          if (pkt_byte_i == ProtoTcp) begin
            l4k_d   = L4Tcp;
            verd_d  = VerdictOk;
            phase_d = PhTcp;
          end else if (pkt_byte_i == ProtoUdp) begin
            l4_d    = UdpHdrLen;
            l4k_d   = L4Udp;
            verd_d  = VerdictOk;
            phase_d = PhDone;
          end else begin
            l4_d    = '0;
            l4k_d   = L4None;
            verd_d  = VerdictNotL4;
            phase_d = PhDone;
          end
        end
      end
      PhTcp: begin
        if (off_q == pos_tcp) begin
          l4_d    = {pkt_byte_i[7:4], 2'b00};
          l4k_d   = L4Tcp;
          verd_d  = VerdictOk;
          phase_d = PhDone;
        end
      end
      default: ;
    endcase

    if (phase_d != PhDone) begin
      verd_d = last_byte_i ? VerdictTrunc : verd_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      off_q   <= '0;
      phase_q <= PhEth;
      prev_q  <= '0;
      tag_q   <= '0;
      l2_q    <= EthHdrLen;
      l3_q    <= '0;
      l4_q    <= '0;
      l3k_q   <= L3None;
      l4k_q   <= L4None;
      verd_q  <= VerdictOk;
    end else if (accept) begin
      if (last_byte_i) begin
        off_q   <= '0;
        phase_q <= PhEth;
        prev_q  <= '0;
        tag_q   <= '0;
        l2_q    <= EthHdrLen;
        l3_q    <= '0;
        l4_q    <= '0;
        l3k_q   <= L3None;
        l4k_q   <= L4None;
        verd_q  <= VerdictOk;
      end else begin
        off_q   <= off_d;
        phase_q <= phase_d;
        prev_q  <= pkt_byte_i;
        tag_q   <= tag_d;
        l2_q    <= l2_d;
        l3_q    <= l3_d;
        l4_q    <= l4_d;
        l3k_q   <= l3k_d;
        l4k_q   <= l4k_d;
        verd_q  <= verd_d;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept && last_byte_i) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && last_byte_i) begin
      res_l2_q   <= l2_d;
      res_l3_q   <= l3_d;
      res_l4_q   <= l4_d;
      res_l3k_q  <= l3k_d;
      res_l4k_q  <= l4k_d;
      res_verd_q <= verd_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign l2_length_o = res_l2_q;
  assign l3_length_o = res_l3_q;
  assign l4_length_o = res_l4_q;
  assign l3_kind_o   = res_l3k_q;
  assign l4_kind_o   = res_l4k_q;
  assign verdict_o   = res_verd_q;

endmodule

### design/phlp_checker.sv
// Port-level assertions for the packet header length parser, bound to the top level.
module phlp_checker
  import phlp_pkg::*;
(
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_o,
  input logic       last_byte_i,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [4:0] l2_length_o,
  input logic [5:0] l3_length_o,
  input logic [5:0] l4_length_o,
  input logic [1:0] l3_kind_o,
  input logic [1:0] l4_kind_o,
  input logic [2:0] verdict_o
);

  // A stalled result stays put.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(verdict_o) &&
    $stable(l2_length_o) && $stable(l3_length_o) && $stable(l4_length_o))
    else $error("result changed while stalled");

  // A result only follows the transfer of a last byte.
  a_out_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && in_ready_o && last_byte_i))
    else $error("result without a last byte");

  a_not_ip: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && verdict_o == VerdictNotIp |->
    l3_length_o == 6'd0 && l4_length_o == 6'd0 && l3_kind_o == L3None &&
    l4_kind_o == L4None)
    else $error("non-IP frame carries L3/L4 fields");

  a_ok_kinds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (verdict_o == VerdictOk || verdict_o == VerdictNotL4) |->
    l3_kind_o != L3None && (verdict_o == VerdictOk) == (l4_kind_o != L4None))
    else $error("verdict disagrees with kinds");

  a_udp_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && l4_kind_o == L4Udp |-> l4_length_o == UdpHdrLen)
    else $error("UDP header length wrong");

endmodule

bind packet_header_length_parser phlp_checker u_phlp_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .last_byte_i (last_byte_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .l2_length_o (l2_length_o),
  .l3_length_o (l3_length_o),
  .l4_length_o (l4_length_o),
  .l3_kind_o   (l3_kind_o),
  .l4_kind_o   (l4_kind_o),
  .verdict_o   (verdict_o)
);

### test/packet_header_length_parser_tb.sv
// Testbench for packet_header_length_parser: byte stimulus, length predictor, result checks.
module packet_header_length_parser_tb;
  import phlp_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int MaxTags    = 4;
  localparam int OffsetBits = 11;
  localparam int RandBytes  = 930;
  localparam int QuietLimit = 1000;
  localparam int TailCycles = 10;

  typedef struct packed {
    logic [4:0] l2;
    logic [5:0] l3;
    logic [5:0] l4;
    logic [1:0] l3k;
    logic [1:0] l4k;
    logic [2:0] verdict;
  } hdr_result_t;

  typedef struct {
    logic [7:0] data;
    logic       is_last;
    bit         drain;
  } wire_byte_t;

  logic       clk_i       = 1'b0;
  logic       rst_ni      = 1'b0;
  logic       in_valid_i  = 1'b0;
  logic       in_ready_o;
  logic [7:0] pkt_byte_i  = 8'h00;
  logic       last_byte_i = 1'b0;
  logic       out_valid_o;
  logic       out_ready_i = 1'b0;
  logic [4:0] l2_length_o;
  logic [5:0] l3_length_o;
  logic [5:0] l4_length_o;
  logic [1:0] l3_kind_o;
  logic [1:0] l4_kind_o;
  logic [2:0] verdict_o;

  packet_header_length_parser #(
    .MAX_TAGS   (MaxTags),
    .OFFSET_BITS(OffsetBits)
  ) dut (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_ready_o,
    .pkt_byte_i,
    .last_byte_i,
    .out_valid_o,
    .out_ready_i,
    .l2_length_o,
    .l3_length_o,
    .l4_length_o,
    .l3_kind_o,
    .l4_kind_o,
    .verdict_o
  );

  always #1 clk_i = ~clk_i;

  wire_byte_t  byte_q[$];
  logic [7:0]  frame_bytes[$];
  hdr_result_t hdr_expect_q[$];

  int bytes_offered = 0;
  int bytes_taken   = 0;
  int results_taken = 0;
  int results_seen  = 0;
  int bad_results   = 0;
  int quiet_cycles  = 0;
  int send_gap      = 0;
  int recv_stall    = 0;
  bit send_idle_on  = 1'b1;
  bit recv_idle_on  = 1'b1;

  // parser state mirror
  int          hp_ofs;
  logic [2:0]  hp_phase;
  logic [15:0] hp_etype;
  int          hp_tags;
  logic [4:0]  hp_l2;
  logic [5:0]  hp_l3;
  logic [5:0]  hp_l4;
  logic [1:0]  hp_l3k;
  logic [1:0]  hp_l4k;
  logic [2:0]  hp_verdict;

  function automatic void clear_parse_state();
    hp_ofs     = 0;
    hp_phase   = PhEth;
    hp_etype   = '0;
    hp_tags    = 0;
    hp_l2      = EthHdrLen;
    hp_l3      = '0;
    hp_l4      = '0;
    hp_l3k     = L3None;
    hp_l4k     = L4None;
    hp_verdict = VerdictOk;
  endfunction

  function automatic void classify_l4_proto(logic [7:0] proto);
    if (proto == ProtoTcp) begin
      hp_l4k     = L4Tcp;
      hp_verdict = VerdictOk;
      hp_phase   = PhTcp;
    end else if (proto == ProtoUdp) begin
      hp_l4      = UdpHdrLen;
      hp_l4k     = L4Udp;
      hp_verdict = VerdictOk;
      hp_phase   = PhDone;
    end else begin
      hp_l4      = '0;
      hp_l4k     = L4None;
      hp_verdict = VerdictNotL4;
      hp_phase   = PhDone;
    end
  endfunction

  function automatic void parse_hdr_byte(logic [7:0] b, logic is_last);
    int base;
    base     = 14 + 4 * hp_tags;
    hp_etype = {hp_etype[7:0], b};
    case (hp_phase)
      PhEth: begin
        if (hp_ofs == base - 1) begin
          if (hp_etype == EtypeVlan || hp_etype == EtypeQinq) begin
            if (hp_tags >= MaxTags) begin
              hp_l3k     = L3None;
              hp_l4k     = L4None;
              hp_verdict = VerdictTags;
              hp_phase   = PhDone;
            end else begin
              hp_tags = hp_tags + 1;
              hp_l2   = 5'(14 + 4 * hp_tags);
            end
          end else if (hp_etype == EtypeIpv4) begin
            hp_l3k     = L3Ipv4;
            hp_l4k     = L4None;
            hp_verdict = VerdictOk;
            hp_phase   = PhIpv4;
          end else if (hp_etype == EtypeIpv6) begin
            hp_l3      = Ipv6HdrLen;
            hp_l3k     = L3Ipv6;
            hp_l4k     = L4None;
            hp_verdict = VerdictOk;
            hp_phase   = PhIpv6;
          end else begin
            hp_l3k     = L3None;
            hp_l4k     = L4None;
            hp_verdict = VerdictNotIp;
            hp_phase   = PhDone;
          end
        end
      end
      PhIpv4: begin
        if (hp_ofs == base) hp_l3 = {b[3:0], 2'b00};
        else if (hp_ofs == base + 9) classify_l4_proto(b);
      end
      PhIpv6: begin
        if (hp_ofs == base + 6) classify_l4_proto(b);
      end
      PhTcp: begin
        if (hp_ofs == base + int'(hp_l3) + 12) begin
          hp_l4      = {b[7:4], 2'b00};
          hp_l4k     = L4Tcp;
          hp_verdict = VerdictOk;
          hp_phase   = PhDone;
        end
      end
      default: ;
    endcase
    if (hp_ofs < (1 << OffsetBits) - 1) hp_ofs++;
    if (is_last) begin
      if (hp_phase != PhDone) hp_verdict = VerdictTrunc;
      hdr_expect_q.push_back({hp_l2, hp_l3, hp_l4, hp_l3k, hp_l4k, hp_verdict});
      clear_parse_state();
    end
  endfunction

  function automatic int draw_wait(inout bit idle_on);
    if ($urandom_range(0, 63) == 0) idle_on = !idle_on;
    return idle_on ? $urandom_range(0, 10) : 0;
  endfunction

  function automatic void put_byte(int idx, logic [7:0] v);
    if (idx < frame_bytes.size()) frame_bytes[idx] = v;
  endfunction

  // len 0 means full headers plus a few payload bytes
  function automatic void queue_frame(int ntags, logic [15:0] etype, logic [7:0] ip0,
                                      logic [7:0] proto, logic [7:0] tcp_b, int len,
                                      bit drain);
    int base;
    int l3;
    int need;
    int total;
    int pos;
    logic [15:0] tag;
    base = 14 + 4 * ntags;
    l3   = -1;
    if (etype == EtypeIpv4) l3 = 4 * ip0[3:0];
    else if (etype == EtypeIpv6) l3 = 40;
    need  = (l3 < 0) ? base : base + l3 + 20;
    total = (len > 0) ? len : need + $urandom_range(0, 6);
    frame_bytes.delete();
    for (int i = 0; i < total; i++) frame_bytes.push_back(8'($urandom));
    pos = 12;
    for (int t = 0; t < ntags; t++) begin
      tag = $urandom_range(0, 1) ? EtypeVlan : EtypeQinq;
      put_byte(pos, tag[15:8]);
      put_byte(pos + 1, tag[7:0]);
      pos += 4;
    end
    put_byte(pos, etype[15:8]);
    put_byte(pos + 1, etype[7:0]);
    pos += 2;
    if (etype == EtypeIpv4) begin
      put_byte(pos, ip0);
      put_byte(pos + 9, proto);
    end else if (etype == EtypeIpv6) begin
      put_byte(pos + 6, proto);
    end
    if (l3 >= 0 && proto == ProtoTcp) put_byte(pos + l3 + 12, tcp_b);
    for (int i = 0; i < total; i++)
      byte_q.push_back('{data: frame_bytes[i], is_last: (i == total - 1),
                         drain: (drain && i == 0)});
  endfunction

  // byte side driver
  always @(negedge clk_i) begin
    wire_byte_t nxt;
    if (rst_ni && !(in_valid_i && bytes_taken != bytes_offered)) begin
      if (in_valid_i) send_gap = draw_wait(send_idle_on);
      if (send_gap > 0) begin
        send_gap--;
        in_valid_i <= 1'b0;
      end else if (byte_q.size() != 0 && !(byte_q[0].drain && hdr_expect_q.size() != 0)) begin
        nxt = byte_q.pop_front();
        pkt_byte_i  <= nxt.data;
        last_byte_i <= nxt.is_last;
        in_valid_i  <= 1'b1;
        bytes_offered++;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // result side ready
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (results_taken != results_seen) begin
        results_seen = results_taken;
        recv_stall   = draw_wait(recv_idle_on);
      end
      if (recv_stall > 0 && out_valid_o) recv_stall--;
      out_ready_i <= (recv_stall == 0);
    end
  end

  // monitor, checker and watchdog
  always @(posedge clk_i) begin
    hdr_result_t got;
    hdr_result_t want;
    bit moved;
    if (rst_ni) begin
      moved = 1'b0;
      if (in_valid_i && in_ready_o) begin
        moved = 1'b1;
        bytes_taken++;
        parse_hdr_byte(pkt_byte_i, last_byte_i);
      end
      if (out_valid_o && out_ready_i) begin
        moved = 1'b1;
        results_taken++;
        got = {l2_length_o, l3_length_o, l4_length_o, l3_kind_o, l4_kind_o, verdict_o};
        if (hdr_expect_q.size() == 0) begin
          bad_results++;
          if (bad_results <= 10)
            $display("%0t: unexpected result l2=%0d l3=%0d l4=%0d l3k=%0d l4k=%0d v=%0d",
                     $time, got.l2, got.l3, got.l4, got.l3k, got.l4k, got.verdict);
        end else begin
          want = hdr_expect_q.pop_front();
          if (got.l2 !== want.l2 || got.l3 !== want.l3 || got.l4 !== want.l4 ||
              got.l3k !== want.l3k || got.l4k !== want.l4k ||
              got.verdict !== want.verdict) begin
            bad_results++;
            if (bad_results <= 10) begin
              $display("%0t: mismatch exp l2=%0d l3=%0d l4=%0d l3k=%0d l4k=%0d v=%0d",
                       $time, want.l2, want.l3, want.l4, want.l3k, want.l4k, want.verdict);
              $display("%0t:          got l2=%0d l3=%0d l4=%0d l3k=%0d l4k=%0d v=%0d",
                       $time, got.l2, got.l3, got.l4, got.l3k, got.l4k, got.verdict);
            end
          end
        end
      end
      quiet_cycles = moved ? 0 : quiet_cycles + 1;
      if (quiet_cycles >= QuietLimit) begin
        $display("%0t: no transfer for %0d cycles", $time, QuietLimit);
        $display("packet_header_length_parser verification failed");
        $finish;
      end
    end
  end

  initial begin
    int ntags;
    int pick;
    int len;
    logic [15:0] etype;
    logic [7:0] proto;
    logic [7:0] ip0;
    clear_parse_state();

    queue_frame(0, EtypeIpv4, 8'h45, ProtoTcp, 8'h50, 0, 1);
    queue_frame(0, EtypeIpv4, 8'h45, ProtoUdp, 8'h00, 0, 0);
    queue_frame(0, EtypeIpv6, 8'h60, ProtoTcp, 8'hF0, 0, 0);
    queue_frame(0, EtypeIpv6, 8'h60, ProtoUdp, 8'hFF, 0, 1);
    queue_frame(0, EtypeIpv4, 8'h45, 8'd1, 8'h50, 0, 0);
    queue_frame(0, EtypeIpv6, 8'h60, 8'd58, 8'h50, 0, 0);
    queue_frame(0, 16'h0806, 8'h45, ProtoTcp, 8'h50, 0, 0);
    queue_frame(0, 16'h0000, 8'h00, 8'h00, 8'h00, 0, 0);
    queue_frame(0, 16'hFFFF, 8'hFF, 8'hFF, 8'hFF, 0, 0);
    queue_frame(1, EtypeIpv4, 8'hFF, ProtoTcp, 8'hFF, 0, 0);
    queue_frame(2, EtypeIpv6, 8'h60, ProtoUdp, 8'h00, 0, 0);
    queue_frame(MaxTags, EtypeIpv4, 8'h40, ProtoTcp, 8'h0F, 0, 1);
    queue_frame(MaxTags + 1, EtypeIpv4, 8'h45, ProtoTcp, 8'h50, 0, 0);
    queue_frame(3, 16'h0806, 8'h45, ProtoUdp, 8'h50, 0, 0);
    // truncated at each parse stage
    queue_frame(0, EtypeIpv4, 8'h45, ProtoTcp, 8'h50, 1, 0);
    queue_frame(0, EtypeIpv4, 8'h45, ProtoTcp, 8'h50, 13, 0);
    queue_frame(0, EtypeIpv4, 8'h45, ProtoTcp, 8'h50, 14, 0);
    queue_frame(0, EtypeIpv4, 8'h45, ProtoTcp, 8'h50, 23, 0);
    queue_frame(0, EtypeIpv4, 8'h45, ProtoTcp, 8'h50, 40, 0);
    queue_frame(0, EtypeIpv6, 8'h60, ProtoTcp, 8'h50, 20, 0);
    queue_frame(0, EtypeIpv6, 8'h60, ProtoTcp, 8'h50, 60, 0);
    queue_frame(2, EtypeIpv4, 8'h45, ProtoTcp, 8'h50, 16, 0);
    queue_frame(MaxTags + 1, EtypeIpv4, 8'h45, ProtoTcp, 8'h50, 14 + 4 * MaxTags + 2, 0);

    len = byte_q.size() + RandBytes;
    while (byte_q.size() < len) begin
      pick  = $urandom_range(0, 9);
      ntags = (pick < 6) ? $urandom_range(0, 2) : $urandom_range(0, MaxTags + 1);
      pick  = $urandom_range(0, 99);
      if (pick < 45) etype = EtypeIpv4;
      else if (pick < 80) etype = EtypeIpv6;
      else if (pick < 85) etype = $urandom_range(0, 1) ? EtypeVlan : EtypeQinq;
      else etype = 16'($urandom);
      pick = $urandom_range(0, 99);
      if (pick < 40) proto = ProtoTcp;
      else if (pick < 75) proto = ProtoUdp;
      else proto = 8'($urandom);
      ip0 = 8'($urandom);
      if ($urandom_range(0, 3) != 0) ip0[3:0] = 4'($urandom_range(5, 15));
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
        queue_frame($urandom_range(0, 1), 16'($urandom), 8'($urandom), 8'($urandom),
                    8'($urandom), $urandom_range(1, 60), 0);
      end else begin
        queue_frame(ntags, etype, ip0, proto, 8'($urandom),
                    (pick < 85) ? 0 : $urandom_range(1, 14 + 4 * ntags + 60),
                    $urandom_range(0, 39) == 0);
      end
    end

    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;

    while (byte_q.size() != 0 || bytes_taken != bytes_offered || hdr_expect_q.size() != 0)
      @(negedge clk_i);
    repeat (TailCycles) @(negedge clk_i);

    if (bad_results == 0 && hdr_expect_q.size() == 0) begin
      $display("packet_header_length_parser verification clean");
    end else begin
      $display("packet_header_length_parser verification failed");
    end
    $finish;
  end

endmodule
